// File: hdl/dtc_pkg.sv
// shared constants, register codes and a crc helper for the disk transfer controller
package dtc_pkg;

    localparam int DISK_DEPTH = 65536;
    localparam int ADDR_W     = $clog2(DISK_DEPTH);
    localparam logic [17:0] DEPTH_LIM = 18'(DISK_DEPTH);

    // item kinds
    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_TICK  = 3'd2;
    localparam logic [2:0] MODE_LOAD  = 3'd3;
    localparam logic [2:0] MODE_MEDIA = 3'd4;

    // bus register offsets
    localparam logic [4:0] OFF_RELOAD_LO = 5'd0;
    localparam logic [4:0] OFF_RELOAD_HI = 5'd1;
    localparam logic [4:0] OFF_TIMER_CTL = 5'd2;
    localparam logic [4:0] OFF_ENABLE    = 5'd3;
    localparam logic [4:0] OFF_WDATA     = 5'd4;
    localparam logic [4:0] OFF_DRIVE_CTL = 5'd5;
    localparam logic [4:0] OFF_LAST_WR   = 5'd6;
    localparam logic [4:0] OFF_STATUS    = 5'd16;
    localparam logic [4:0] OFF_RDATA     = 5'd17;
    localparam logic [4:0] OFF_DRIVE_ST  = 5'd18;
    localparam logic [4:0] OFF_BATTERY   = 5'd19;

    // configuration register indexes
    localparam logic [1:0] CFG_SIDE_LEN = 2'd0;
    localparam logic [1:0] CFG_SPINUP   = 2'd1;
    localparam logic [1:0] CFG_BYTE_DLY = 2'd2;

    localparam logic [16:0] SIDE_LEN_RST = 17'd65500;
    localparam logic [15:0] SPINUP_RST   = 16'd50000;
    localparam logic [15:0] BYTE_DLY_RST = 16'd150;

    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_DBIT = 16'h8000;

    localparam logic [7:0] BATTERY_OK = 8'h80;
    localparam logic [7:0] NO_DISK_ST = 8'h07;
    localparam logic [7:0] IDLE_ST    = 8'h02;

    // timer flags
    localparam int TF_EN = 0, TF_REP = 1, TF_PEND = 2;
    // enable flags
    localparam int EF_DISK = 0, EF_SND = 1;
    // drive control
    localparam int DC_MOTOR = 0, DC_RST = 1, DC_READ = 2, DC_MIRR = 3;
    localparam int DC_CRC = 4, DC_READY = 6, DC_IRQEN = 7;
    // head flags
    localparam int HF_END = 0, HF_SCAN = 1, HF_GAP = 2, HF_PCRC = 3, HF_DONE = 4;

    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] r;
        r = c;
        for (int b = 0; b < 8; b++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            if (v[b])
            begin
                r = r ^ CRC_DBIT;
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/dtc_if.sv
// handshake channels: request items, result items, configuration writes
interface dtc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [4:0]  reg_offset;
    logic [7:0]  data_in;
    logic [15:0] image_addr;
    modport source (output valid, mode, reg_offset, data_in, image_addr, input ready);
    modport sink   (input valid, mode, reg_offset, data_in, image_addr, output ready);
endinterface

interface dtc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       handled;
    logic       irq_line;
    logic       mirror_horizontal;
    logic       sound_regs_on;
    modport source (output valid, read_data, handled, irq_line, mirror_horizontal,
                    sound_regs_on, input ready);
    modport sink   (input valid, read_data, handled, irq_line, mirror_horizontal,
                    sound_regs_on, output ready);
endinterface

interface dtc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/dtc_store.sv
// disk image memory, one write and one registered read port with write forwarding
module dtc_store
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [dtc_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                 wdata,
    input  logic [dtc_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                 rdata
);
    logic [7:0] mem [dtc_pkg::DISK_DEPTH];
    logic [7:0] q_reg;
    logic [7:0] fwd_reg;
    logic       hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg   <= mem[raddr];
        fwd_reg <= wdata;
        hit_reg <= we && (waddr == raddr);
    end

    assign rdata = hit_reg ? fwd_reg : q_reg;
endmodule

// File: hdl/disk_transfer_controller_irq_timer.sv
// disk transfer controller: results are registered, valid the cycle after acceptance
// throughput one item per cycle unless rsp stalls; results held in an output register
// the next head byte is prefetched from the store's registered read at pos_next
// reset returns control state to reset values; disk image memory is not cleared
// config registers reset to side 65500, spin-up 50000, byte delay 150
module disk_transfer_controller_irq_timer
(
    input logic        clk,
    input logic        rst_n,
    dtc_req_if.sink    req,
    dtc_rsp_if.source  rsp,
    dtc_cfg_if.sink    cfg
);
    logic [16:0] side_len_reg;
    logic [15:0] spinup_reg, bdelay_reg;
    logic [15:0] reload_reg, reload_next, count_reg, count_next;
    logic [2:0]  tf_reg, tf_next;
    logic [1:0]  ef_reg, ef_next;
    logic [7:0]  dc_reg, dc_next;
    logic [4:0]  hf_reg, hf_next;
    logic [15:0] wait_reg, wait_next, crc_reg, crc_next;
    logic [16:0] pos_reg, pos_next;
    logic [7:0]  rbyte_reg, rbyte_next, wbyte_reg, wbyte_next;
    logic        dirq_reg, dirq_next, present_reg, present_next;
    logic        ovalid_reg;
    logic [7:0]  rdata_reg, rdata_next;
    logic        handled_reg, handled_next;

    logic                       accept;
    logic                       we;
    logic [dtc_pkg::ADDR_W-1:0] waddr;
    logic [7:0]                 wdata;
    logic [7:0]                 mem_q;

    assign req.ready = !ovalid_reg || rsp.ready;
    assign accept = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    dtc_store u_store
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (pos_next[dtc_pkg::ADDR_W-1:0]),
        .rdata (mem_q)
    );

    always_comb
    begin
        logic [7:0]  d;
        logic        need_irq;
        logic        crc_on;
        logic [16:0] w;
        logic [16:0] p1;
        reload_next = reload_reg;
        count_next = count_reg;
        tf_next = tf_reg;
        ef_next = ef_reg;
        dc_next = dc_reg;
        hf_next = hf_reg;
        wait_next = wait_reg;
        crc_next = crc_reg;
        pos_next = pos_reg;
        rbyte_next = rbyte_reg;
        wbyte_next = wbyte_reg;
        dirq_next = dirq_reg;
        present_next = present_reg;
        rdata_next = 8'h00;
        handled_next = 1'b0;
        we = 1'b0;
        waddr = req.image_addr[dtc_pkg::ADDR_W-1:0];
        wdata = req.data_in;
        d = 8'h00;
        need_irq = 1'b0;
        crc_on = 1'b0;
        w = 17'd0;
        p1 = 17'd0;
        if (accept)
        begin
            case (req.mode)
                dtc_pkg::MODE_WRITE:
                begin
                    if (req.reg_offset <= dtc_pkg::OFF_LAST_WR)
                    begin
                        handled_next = 1'b1;
                        if (ef_reg[dtc_pkg::EF_DISK] || req.reg_offset < dtc_pkg::OFF_WDATA)
                        begin
                            unique case (req.reg_offset)
                                dtc_pkg::OFF_RELOAD_LO: reload_next[7:0] = req.data_in;
                                dtc_pkg::OFF_RELOAD_HI: reload_next[15:8] = req.data_in;
                                dtc_pkg::OFF_TIMER_CTL:
                                begin
                                    tf_next[dtc_pkg::TF_REP] = req.data_in[0];
                                    tf_next[dtc_pkg::TF_EN] = 1'b0;
                                    if (req.data_in[1] && ef_reg[dtc_pkg::EF_DISK])
                                    begin
                                        tf_next[dtc_pkg::TF_EN] = 1'b1;
                                        count_next = reload_reg;
                                    end
                                    else
                                    begin
                                        tf_next[dtc_pkg::TF_PEND] = 1'b0;
                                    end
                                end
                                dtc_pkg::OFF_ENABLE:
                                begin
                                    ef_next = req.data_in[1:0];
                                    if (!req.data_in[0])
                                    begin
                                        tf_next[dtc_pkg::TF_EN] = 1'b0;
                                        tf_next[dtc_pkg::TF_PEND] = 1'b0;
                                        dirq_next = 1'b0;
                                    end
                                end
                                dtc_pkg::OFF_WDATA:
                                begin
                                    wbyte_next = req.data_in;
                                    hf_next[dtc_pkg::HF_DONE] = 1'b0;
                                    dirq_next = 1'b0;
                                end
                                dtc_pkg::OFF_DRIVE_CTL:
                                begin
                                    dc_next = req.data_in;
                                    dirq_next = 1'b0;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                dtc_pkg::MODE_READ:
                begin
                    if (ef_reg[dtc_pkg::EF_DISK] && req.reg_offset >= dtc_pkg::OFF_STATUS
                        && req.reg_offset <= dtc_pkg::OFF_BATTERY)
                    begin
                        handled_next = 1'b1;
                        unique case (req.reg_offset)
                            dtc_pkg::OFF_STATUS:
                            begin
                                rdata_next = {6'd0, hf_reg[dtc_pkg::HF_DONE],
                                              tf_reg[dtc_pkg::TF_PEND]};
                                hf_next[dtc_pkg::HF_DONE] = 1'b0;
                                tf_next[dtc_pkg::TF_PEND] = 1'b0;
                                dirq_next = 1'b0;
                            end
                            dtc_pkg::OFF_RDATA:
                            begin
                                hf_next[dtc_pkg::HF_DONE] = 1'b0;
                                dirq_next = 1'b0;
                                rdata_next = rbyte_reg;
                            end
                            dtc_pkg::OFF_DRIVE_ST:
                            begin
                                if (!present_reg)
                                begin
                                    rdata_next = dtc_pkg::NO_DISK_ST;
                                end
                                else if (!hf_reg[dtc_pkg::HF_SCAN])
                                begin
                                    rdata_next = dtc_pkg::IDLE_ST;
                                end
                            end
                            default: rdata_next = dtc_pkg::BATTERY_OK;
                        endcase
                    end
                end
                dtc_pkg::MODE_TICK:
                begin
                    if (tf_reg[dtc_pkg::TF_EN])
                    begin
                        if (count_reg == 16'd0)
                        begin
                            tf_next[dtc_pkg::TF_PEND] = 1'b1;
                            count_next = reload_reg;
                            if (!tf_reg[dtc_pkg::TF_REP])
                            begin
                                tf_next[dtc_pkg::TF_EN] = 1'b0;
                            end
                        end
                        else
                        begin
                            count_next = count_reg - 16'd1;
                        end
                    end
                    // head clock
                    if (!present_reg || !dc_reg[dtc_pkg::DC_MOTOR])
                    begin
                        hf_next[dtc_pkg::HF_END] = 1'b1;
                        hf_next[dtc_pkg::HF_SCAN] = 1'b0;
                    end
                    else if (dc_reg[dtc_pkg::DC_RST] && !hf_reg[dtc_pkg::HF_SCAN])
                    begin
                        hf_next = hf_reg;
                    end
                    else if (hf_reg[dtc_pkg::HF_END])
                    begin
                        wait_next = spinup_reg;
                        hf_next[dtc_pkg::HF_END] = 1'b0;
                        hf_next[dtc_pkg::HF_GAP] = 1'b0;
                        pos_next = 17'd0;
                    end
                    else if (wait_reg != 16'd0)
                    begin
                        wait_next = wait_reg - 16'd1;
                    end
                    else
                    begin
                        hf_next[dtc_pkg::HF_SCAN] = 1'b1;
                        if (pos_reg >= side_len_reg)
                        begin
                            dc_next[dtc_pkg::DC_MOTOR] = 1'b0;
                        end
                        else
                        begin
                            need_irq = dc_reg[dtc_pkg::DC_IRQEN];
                            if (dc_reg[dtc_pkg::DC_READ])
                            begin
                                d = ({1'b0, pos_reg} < dtc_pkg::DEPTH_LIM) ? mem_q : 8'h00;
                                if (!hf_reg[dtc_pkg::HF_PCRC])
                                begin
                                    crc_next = dtc_pkg::crc_feed(crc_reg, d);
                                end
                                if (!dc_reg[dtc_pkg::DC_READY])
                                begin
                                    hf_next[dtc_pkg::HF_GAP] = 1'b0;
                                    crc_next = 16'd0;
                                end
                                else if (d != 8'h00 && !hf_reg[dtc_pkg::HF_GAP])
                                begin
                                    hf_next[dtc_pkg::HF_GAP] = 1'b1;
                                    need_irq = 1'b0;
                                end
                                if (hf_next[dtc_pkg::HF_GAP])
                                begin
                                    hf_next[dtc_pkg::HF_DONE] = 1'b1;
                                    rbyte_next = d;
                                    if (need_irq)
                                    begin
                                        dirq_next = 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                crc_on = dc_reg[dtc_pkg::DC_CRC];
                                if (!crc_on)
                                begin
                                    hf_next[dtc_pkg::HF_DONE] = 1'b1;
                                    d = wbyte_reg;
                                    if (need_irq)
                                    begin
                                        dirq_next = 1'b1;
                                    end
                                end
                                if (!dc_reg[dtc_pkg::DC_READY])
                                begin
                                    d = 8'h00;
                                end
                                if (!crc_on)
                                begin
                                    crc_next = dtc_pkg::crc_feed(crc_reg, d);
                                end
                                else
                                begin
                                    crc_next = crc_reg;
                                    // two zero bytes flush the crc before it goes out
                                    if (!hf_reg[dtc_pkg::HF_PCRC])
                                    begin
                                        crc_next = dtc_pkg::crc_feed(
                                            dtc_pkg::crc_feed(crc_reg, 8'h00), 8'h00);
                                    end
                                    d = crc_next[7:0];
                                    crc_next = crc_next >> 8;
                                end
                                if (pos_reg >= 17'd2)
                                begin
                                    w = pos_reg - 17'd2;
                                    if (w < side_len_reg && {1'b0, w} < dtc_pkg::DEPTH_LIM)
                                    begin
                                        we = 1'b1;
                                        waddr = w[dtc_pkg::ADDR_W-1:0];
                                        wdata = d;
                                    end
                                end
                                hf_next[dtc_pkg::HF_GAP] = 1'b0;
                            end
                            hf_next[dtc_pkg::HF_PCRC] = dc_reg[dtc_pkg::DC_CRC];
                            p1 = pos_reg + 17'd1;
                            pos_next = p1;
                            if (p1 >= side_len_reg)
                            begin
                                dc_next[dtc_pkg::DC_MOTOR] = 1'b0;
                            end
                            else
                            begin
                                wait_next = bdelay_reg;
                            end
                        end
                    end
                end
                dtc_pkg::MODE_LOAD:
                begin
                    if ({2'b00, req.image_addr} < dtc_pkg::DEPTH_LIM)
                    begin
                        we = 1'b1;
                    end
                end
                dtc_pkg::MODE_MEDIA:
                begin
                    present_next = req.data_in[0];
                    hf_next = 5'd0;
                    hf_next[dtc_pkg::HF_END] = 1'b1;
                    wait_next = 16'd0;
                    pos_next = 17'd0;
                    crc_next = 16'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_len_reg <= dtc_pkg::SIDE_LEN_RST;
            spinup_reg <= dtc_pkg::SPINUP_RST;
            bdelay_reg <= dtc_pkg::BYTE_DLY_RST;
            reload_reg <= 16'd0;
            count_reg <= 16'd0;
            tf_reg <= 3'd0;
            ef_reg <= 2'd0;
            dc_reg <= 8'h04;
            hf_reg <= 5'd1;
            wait_reg <= 16'd0;
            crc_reg <= 16'd0;
            pos_reg <= 17'd0;
            rbyte_reg <= 8'd0;
            wbyte_reg <= 8'd0;
            dirq_reg <= 1'b0;
            present_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            rdata_reg <= 8'd0;
            handled_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    dtc_pkg::CFG_SIDE_LEN: side_len_reg <= cfg.data;
                    dtc_pkg::CFG_SPINUP:   spinup_reg <= cfg.data[15:0];
                    dtc_pkg::CFG_BYTE_DLY: bdelay_reg <= cfg.data[15:0];
                    default: ;
                endcase
            end
            reload_reg <= reload_next;
            count_reg <= count_next;
            tf_reg <= tf_next;
            ef_reg <= ef_next;
            dc_reg <= dc_next;
            hf_reg <= hf_next;
            wait_reg <= wait_next;
            crc_reg <= crc_next;
            pos_reg <= pos_next;
            rbyte_reg <= rbyte_next;
            wbyte_reg <= wbyte_next;
            dirq_reg <= dirq_next;
            present_reg <= present_next;
            if (accept)
            begin
                ovalid_reg <= 1'b1;
                rdata_reg <= rdata_next;
                handled_reg <= handled_next;
            end
            else if (rsp.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // status bits are only changed by accepted items, so the live state is the result
    assign rsp.valid = ovalid_reg;
    assign rsp.read_data = rdata_reg;
    assign rsp.handled = handled_reg;
    assign rsp.irq_line = tf_reg[dtc_pkg::TF_PEND] || dirq_reg;
    assign rsp.mirror_horizontal = dc_reg[dtc_pkg::DC_MIRR];
    assign rsp.sound_regs_on = ef_reg[dtc_pkg::EF_SND];
endmodule

// File: sim/testbench.sv
// self-checking testbench for the disk transfer controller with irq timer
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRELOAD_SIZE = 128;
    localparam int PHASE_ITEMS  = 235;

    typedef struct packed {
        logic [7:0] read_data;
        logic       handled;
        logic       irq_line;
        logic       mirror_horizontal;
        logic       sound_regs_on;
    } reply_t;

    class reply_scoreboard;
        reply_t expected_replies[$];
        int     fails;

        function new();
            fails = 0;
        endfunction

        function void note(reply_t r);
            expected_replies.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            fails++;
        endtask

        task check(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0)
            begin
                report("unexpected item", 1, 0);
                return;
            end
            want = expected_replies.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.handled !== want.handled)
                report("handled", got.handled, want.handled);
            if (got.irq_line !== want.irq_line)
                report("irq_line", got.irq_line, want.irq_line);
            if (got.mirror_horizontal !== want.mirror_horizontal)
                report("mirror_horizontal", got.mirror_horizontal, want.mirror_horizontal);
            if (got.sound_regs_on !== want.sound_regs_on)
                report("sound_regs_on", got.sound_regs_on, want.sound_regs_on);
        endtask
    endclass

    logic clk;
    logic rst_n;

    dtc_req_if req_ch();
    dtc_rsp_if rsp_ch();
    dtc_cfg_if cfg_ch();

    disk_transfer_controller_irq_timer i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    reply_scoreboard sb;

    // controller state as predicted
    logic [16:0] side_len;
    logic [15:0] spinup_len;
    logic [15:0] gap_len;
    logic [15:0] reload_val;
    logic [15:0] count_val;
    logic [15:0] wait_val;
    logic [15:0] crc_val;
    logic [2:0]  timer_st;
    logic [1:0]  enable_st;
    logic [7:0]  drive_st;
    logic [4:0]  head_st;
    logic [16:0] head_pos;
    logic [7:0]  last_read;
    logic [7:0]  latch_byte;
    logic        disk_irq;
    logic        media_in;
    logic [7:0]  image_mem [0:dtc_pkg::DISK_DEPTH-1];

    int  cycles;
    int  accepted;
    int  stall_left;
    bit  hold_long;

    function automatic void crc_step(logic [7:0] v);
        logic carry;
        for (int b = 0; b < 8; b++)
        begin
            carry = crc_val[0];
            crc_val = crc_val >> 1;
            if (carry)
                crc_val = crc_val ^ dtc_pkg::CRC_POLY;
            if (v[b])
                crc_val = crc_val ^ dtc_pkg::CRC_DBIT;
        end
    endfunction

    function automatic void restart_head();
        head_st = 5'b0;
        head_st[dtc_pkg::HF_END] = 1'b1;
        wait_val = '0;
        head_pos = '0;
        crc_val = '0;
    endfunction

    function automatic void advance_head();
        logic [7:0]  d;
        logic        want_irq;
        logic        crc_on;
        logic [16:0] w;
        d = '0;
        if (!media_in || !drive_st[dtc_pkg::DC_MOTOR])
        begin
            head_st[dtc_pkg::HF_END] = 1'b1;
            head_st[dtc_pkg::HF_SCAN] = 1'b0;
            return;
        end
        if (drive_st[dtc_pkg::DC_RST] && !head_st[dtc_pkg::HF_SCAN])
            return;
        if (head_st[dtc_pkg::HF_END])
        begin
            wait_val = spinup_len;
            head_st[dtc_pkg::HF_END] = 1'b0;
            head_st[dtc_pkg::HF_GAP] = 1'b0;
            head_pos = '0;
            return;
        end
        if (wait_val > 0)
        begin
            wait_val--;
            return;
        end
        head_st[dtc_pkg::HF_SCAN] = 1'b1;
        if (head_pos >= side_len)
        begin
            drive_st[dtc_pkg::DC_MOTOR] = 1'b0;
            return;
        end
        want_irq = drive_st[dtc_pkg::DC_IRQEN];
        if (drive_st[dtc_pkg::DC_READ])
        begin
            d = (head_pos < dtc_pkg::DISK_DEPTH) ? image_mem[head_pos[15:0]] : 8'h00;
            if (!head_st[dtc_pkg::HF_PCRC])
                crc_step(d);
            if (!drive_st[dtc_pkg::DC_READY])
            begin
                head_st[dtc_pkg::HF_GAP] = 1'b0;
                crc_val = '0;
            end
            else if (d != 0 && !head_st[dtc_pkg::HF_GAP])
            begin
                head_st[dtc_pkg::HF_GAP] = 1'b1;
                want_irq = 1'b0;
            end
            if (head_st[dtc_pkg::HF_GAP])
            begin
                head_st[dtc_pkg::HF_DONE] = 1'b1;
                last_read = d;
                if (want_irq)
                    disk_irq = 1'b1;
            end
        end
        else
        begin
            crc_on = drive_st[dtc_pkg::DC_CRC];
            if (!crc_on)
            begin
                head_st[dtc_pkg::HF_DONE] = 1'b1;
                d = latch_byte;
                if (want_irq)
                    disk_irq = 1'b1;
            end
            if (!drive_st[dtc_pkg::DC_READY])
                d = '0;
            if (!crc_on)
                crc_step(d);
            else
            begin
                if (!head_st[dtc_pkg::HF_PCRC])
                begin
                    crc_step(8'h00);
                    crc_step(8'h00);
                end
                d = crc_val[7:0];
                crc_val = crc_val >> 8;
            end
            if (head_pos >= 2)
            begin
                w = head_pos - 17'd2;
                if (w < side_len && w < dtc_pkg::DISK_DEPTH)
                    image_mem[w[15:0]] = d;
            end
            head_st[dtc_pkg::HF_GAP] = 1'b0;
        end
        head_st[dtc_pkg::HF_PCRC] = drive_st[dtc_pkg::DC_CRC];
        head_pos = head_pos + 17'd1;
        if (head_pos >= side_len)
            drive_st[dtc_pkg::DC_MOTOR] = 1'b0;
        else
            wait_val = gap_len;
    endfunction

    function automatic reply_t predict_reply(logic [2:0] mode, logic [4:0] off,
                                             logic [7:0] v, logic [15:0] ia);
        reply_t r;
        r = '0;
        case (mode)
            dtc_pkg::MODE_WRITE:
            begin
                if (off <= dtc_pkg::OFF_LAST_WR)
                begin
                    r.handled = 1'b1;
                    if (enable_st[dtc_pkg::EF_DISK] || off < dtc_pkg::OFF_WDATA)
                    begin
                        case (off)
                            dtc_pkg::OFF_RELOAD_LO: reload_val[7:0] = v;
                            dtc_pkg::OFF_RELOAD_HI: reload_val[15:8] = v;
                            dtc_pkg::OFF_TIMER_CTL:
                            begin
                                timer_st[dtc_pkg::TF_REP] = v[0];
                                timer_st[dtc_pkg::TF_EN] = 1'b0;
                                if (v[1] && enable_st[dtc_pkg::EF_DISK])
                                begin
                                    timer_st[dtc_pkg::TF_EN] = 1'b1;
                                    count_val = reload_val;
                                end
                                else
                                    timer_st[dtc_pkg::TF_PEND] = 1'b0;
                            end
                            dtc_pkg::OFF_ENABLE:
                            begin
                                enable_st = v[1:0];
                                if (!enable_st[dtc_pkg::EF_DISK])
                                begin
                                    timer_st[dtc_pkg::TF_EN] = 1'b0;
                                    timer_st[dtc_pkg::TF_PEND] = 1'b0;
                                    disk_irq = 1'b0;
                                end
                            end
                            dtc_pkg::OFF_WDATA:
                            begin
                                latch_byte = v;
                                head_st[dtc_pkg::HF_DONE] = 1'b0;
                                disk_irq = 1'b0;
                            end
                            dtc_pkg::OFF_DRIVE_CTL:
                            begin
                                drive_st = v;
                                disk_irq = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            dtc_pkg::MODE_READ:
            begin
                if (enable_st[dtc_pkg::EF_DISK] && off >= dtc_pkg::OFF_STATUS
                    && off <= dtc_pkg::OFF_BATTERY)
                begin
                    r.handled = 1'b1;
                    case (off)
                        dtc_pkg::OFF_STATUS:
                        begin
                            r.read_data = {6'b0, head_st[dtc_pkg::HF_DONE],
                                           timer_st[dtc_pkg::TF_PEND]};
                            head_st[dtc_pkg::HF_DONE] = 1'b0;
                            timer_st[dtc_pkg::TF_PEND] = 1'b0;
                            disk_irq = 1'b0;
                        end
                        dtc_pkg::OFF_RDATA:
                        begin
                            head_st[dtc_pkg::HF_DONE] = 1'b0;
                            disk_irq = 1'b0;
                            r.read_data = last_read;
                        end
                        dtc_pkg::OFF_DRIVE_ST:
                            r.read_data = !media_in ? dtc_pkg::NO_DISK_ST
                                        : (head_st[dtc_pkg::HF_SCAN] ? 8'h00
                                                                     : dtc_pkg::IDLE_ST);
                        default: r.read_data = dtc_pkg::BATTERY_OK;
                    endcase
                end
            end
            dtc_pkg::MODE_TICK:
            begin
                if (timer_st[dtc_pkg::TF_EN])
                begin
                    if (count_val == 0)
                    begin
                        timer_st[dtc_pkg::TF_PEND] = 1'b1;
                        count_val = reload_val;
                        if (!timer_st[dtc_pkg::TF_REP])
                            timer_st[dtc_pkg::TF_EN] = 1'b0;
                    end
                    else
                        count_val--;
                end
                advance_head();
            end
            dtc_pkg::MODE_LOAD: image_mem[ia] = v;
            dtc_pkg::MODE_MEDIA:
            begin
                media_in = v[0];
                restart_head();
            end
            default: ;
        endcase
        r.irq_line = timer_st[dtc_pkg::TF_PEND] | disk_irq;
        r.mirror_horizontal = drive_st[dtc_pkg::DC_MIRR];
        r.sound_regs_on = enable_st[dtc_pkg::EF_SND];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** disk_transfer_controller_irq_timer: FAILED **");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check({rsp_ch.read_data, rsp_ch.handled, rsp_ch.irq_line,
                      rsp_ch.mirror_horizontal, rsp_ch.sound_regs_on});
        if (hold_long)
            rsp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
        end
    end

    initial
    begin
        wait (accepted >= 600);
        hold_long = 1'b1;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
    end

    task send_item(logic [2:0] mode, logic [4:0] off, logic [7:0] v, logic [15:0] ia);
        int gap;
        gap = 0;
        if ($urandom_range(0, 1) == 1)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.reg_offset <= off;
        req_ch.data_in <= v;
        req_ch.image_addr <= ia;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note(predict_reply(mode, off, v, ia));
        accepted++;
    endtask

    task drain();
        req_ch.valid <= 1'b0;
        while (sb.expected_replies.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [16:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            dtc_pkg::CFG_SIDE_LEN: side_len = value;
            dtc_pkg::CFG_SPINUP:   spinup_len = value[15:0];
            dtc_pkg::CFG_BYTE_DLY: gap_len = value[15:0];
            default: ;
        endcase
    endtask

    task random_item();
        int pick;
        logic [4:0] off;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        v = 8'($urandom);
        if (pick < 50)
            send_item(dtc_pkg::MODE_TICK, 5'($urandom), v, 16'($urandom));
        else if (pick < 70)
        begin
            off = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
            if (off == dtc_pkg::OFF_ENABLE && $urandom_range(0, 9) != 0)
                v[0] = 1'b1;
            if (off == dtc_pkg::OFF_DRIVE_CTL && $urandom_range(0, 4) != 0)
                v[0] = 1'b1;
            send_item(dtc_pkg::MODE_WRITE, off, v, 16'($urandom));
        end
        else if (pick < 90)
        begin
            off = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(16, 19));
            send_item(dtc_pkg::MODE_READ, off, v, 16'($urandom));
        end
        else if (pick < 95)
            send_item(dtc_pkg::MODE_LOAD, 5'($urandom), v,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, PRELOAD_SIZE - 1)));
        else if (pick < 98)
            send_item(dtc_pkg::MODE_MEDIA, 5'($urandom),
                      ($urandom_range(0, 4) == 0) ? 8'h00 : 8'h01, 16'($urandom));
        else
            send_item(3'($urandom_range(5, 7)), 5'($urandom), v, 16'($urandom));
    endtask

    task run_phase(logic [16:0] sl, logic [15:0] sp, logic [15:0] bd);
        write_reg(dtc_pkg::CFG_SIDE_LEN, sl);
        write_reg(dtc_pkg::CFG_SPINUP, 17'(sp));
        write_reg(dtc_pkg::CFG_BYTE_DLY, 17'(bd));
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_ENABLE,
                  8'h01 | 8'($urandom_range(0, 1) << 1), '0);
        send_item(dtc_pkg::MODE_MEDIA, '0, 8'h01, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_WDATA, 8'($urandom), '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_DRIVE_CTL, 8'($urandom) | 8'h01, '0);
        repeat (PHASE_ITEMS) random_item();
        drain();
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        accepted = 0;
        stall_left = 0;
        hold_long = 1'b0;
        side_len = dtc_pkg::SIDE_LEN_RST;
        spinup_len = dtc_pkg::SPINUP_RST;
        gap_len = dtc_pkg::BYTE_DLY_RST;
        reload_val = '0;
        count_val = '0;
        timer_st = '0;
        enable_st = '0;
        drive_st = 8'h00;
        drive_st[dtc_pkg::DC_READ] = 1'b1;
        restart_head();
        last_read = '0;
        latch_byte = '0;
        disk_irq = 1'b0;
        media_in = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = dtc_pkg::MODE_TICK;
        req_ch.reg_offset = '0;
        req_ch.data_in = '0;
        req_ch.image_addr = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = dtc_pkg::CFG_SIDE_LEN;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every position the head can reach gets written first
        for (int a = 0; a < PRELOAD_SIZE; a++)
            send_item(dtc_pkg::MODE_LOAD, '0,
                      ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom), 16'(a));

        // directed: disabled registers, timer extremes, odd offsets and modes
        send_item(dtc_pkg::MODE_READ, dtc_pkg::OFF_STATUS, 8'h00, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_DRIVE_CTL, 8'hFF, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_ENABLE, 8'h03, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_RELOAD_LO, 8'hFF, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_RELOAD_HI, 8'hFF, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_TIMER_CTL, 8'h03, '0);
        send_item(dtc_pkg::MODE_READ, dtc_pkg::OFF_STATUS, 8'h00, '0);
        send_item(dtc_pkg::MODE_READ, dtc_pkg::OFF_RDATA, 8'h00, '0);
        send_item(dtc_pkg::MODE_READ, dtc_pkg::OFF_DRIVE_ST, 8'h00, '0);
        send_item(dtc_pkg::MODE_READ, dtc_pkg::OFF_BATTERY, 8'h00, '0);
        send_item(dtc_pkg::MODE_READ, 5'd0, 8'h00, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_LAST_WR, 8'hFF, '0);
        send_item(dtc_pkg::MODE_WRITE, 5'd7, 8'hFF, '0);
        send_item(dtc_pkg::MODE_WRITE, 5'd31, 8'hAA, 16'hFFFF);
        send_item(dtc_pkg::MODE_MEDIA, '0, 8'h01, '0);
        send_item(dtc_pkg::MODE_READ, dtc_pkg::OFF_DRIVE_ST, 8'h00, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_DRIVE_CTL, 8'hCD, '0);
        send_item(dtc_pkg::MODE_TICK, '0, 8'h00, '0);
        send_item(dtc_pkg::MODE_TICK, '0, 8'h00, '0);
        send_item(dtc_pkg::MODE_LOAD, '0, 8'h5A, 16'hFFFF);
        send_item(3'd5, 5'd31, 8'hFF, 16'hFFFF);
        send_item(3'd7, '0, 8'h00, '0);
        send_item(dtc_pkg::MODE_MEDIA, '0, 8'h00, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_ENABLE, 8'h00, '0);
        send_item(dtc_pkg::MODE_READ, dtc_pkg::OFF_DRIVE_ST, 8'h00, '0);
        send_item(dtc_pkg::MODE_WRITE, dtc_pkg::OFF_RELOAD_HI, 8'h00, '0);
        drain();

        run_phase(17'(PRELOAD_SIZE), 16'd0, 16'd0);
        run_phase(17'd0, 16'd3, 16'd2);
        // widest side with the longest delays keeps the head on preloaded bytes
        run_phase(17'd65536, 16'hFFFF, 16'hFFFF);
        run_phase(17'd100, 16'd5, 16'd3);
        run_phase(17'd64, 16'd1, 16'd1);

        if (sb.fails == 0)
            $display("** disk_transfer_controller_irq_timer: PASSED **");
        else
            $display("** disk_transfer_controller_irq_timer: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
hdl/dtc_pkg.sv
hdl/dtc_if.sv
hdl/dtc_store.sv
hdl/disk_transfer_controller_irq_timer.sv
sim/testbench.sv
